>>> sv/rlte_pkg.sv
// Shared types, constants and helper functions of the run-length token encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rlte_pkg;

   localparam int SYMBOL_W      = 8;
   localparam int COUNT_W       = 16;
   localparam int VALUE_W       = 25;
   localparam int LENGTH_W      = 5;
   localparam int SYM_BITS_W    = 4;
   localparam int CNT_BITS_W    = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 32;
   localparam int FIFO_DEPTH    = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_BITS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_BITS    = 2'd2;

   localparam logic [SYMBOL_W-1:0]   RST_SYMBOL_OFFSET = 8'd64;
   localparam logic [SYM_BITS_W-1:0] RST_SYMBOL_BITS   = 4'd3;
   localparam logic [CNT_BITS_W-1:0] RST_COUNT_BITS    = 5'd4;

   typedef struct packed {
      logic [SYMBOL_W-1:0]   symbol_offset;
      logic [SYM_BITS_W-1:0] symbol_bits;
      logic [CNT_BITS_W-1:0] count_bits;
   } cfg_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [COUNT_W-1:0]  count;
      logic                final_token;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [SYM_BITS_W-1:0] eff_sym_bits(input logic [SYM_BITS_W-1:0] raw);
      logic [SYM_BITS_W-1:0] b;
      b = raw;
      if (b == 4'd0) b = 4'd1;
      if (b > 4'd8) b = 4'd8;
      return b;
   endfunction

   function automatic logic [CNT_BITS_W-1:0] eff_cnt_bits(input logic [CNT_BITS_W-1:0] raw);
      logic [CNT_BITS_W-1:0] b;
      b = raw;
      if (b == 5'd0) b = 5'd1;
      if (b > 5'd16) b = 5'd16;
      return b;
   endfunction

   function automatic logic [COUNT_W-1:0] max_count(input logic [CNT_BITS_W-1:0] raw);
      logic [CNT_BITS_W-1:0] cb;
      logic [COUNT_W:0]      m;
      cb = eff_cnt_bits(raw);
      m  = (17'd1 << cb) - 17'd1;
      return m[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/rlte_front.sv
// Front end of the run-length token encoder: accepts characters, tracks the open run
// and pushes one token request per cycle into the queue while it is not full. Depends on rlte_pkg.
`default_nettype none

module rlte_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  rlte_pkg::cfg_type        cfg,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [rlte_pkg::SYMBOL_W-1:0]  req_symbol,
   input  wire                            req_last,
   input  wire  rlte_pkg::fifo_status_type fifo_status,
   output logic                           push_valid,
   output rlte_pkg::entry_type            push_entry
);
   import rlte_pkg::*;

   logic [SYMBOL_W-1:0] run_symbol_ff, run_symbol_in;
   logic [COUNT_W-1:0]  run_count_ff, run_count_in;
   logic                run_open_ff, run_open_in;
   logic                pend_ff, pend_in;
   logic [SYMBOL_W-1:0] pend_symbol_ff, pend_symbol_in;

   logic                accept;
   logic                extend;
   logic [COUNT_W-1:0]  new_count;
   logic [SYMBOL_W-1:0] new_symbol;

   assign req_tready = !pend_ff && !fifo_status.full;
   assign accept     = req_tvalid && req_tready;
   assign extend     = run_open_ff && (req_symbol == run_symbol_ff)
                       && (run_count_ff < max_count(cfg.count_bits));
   assign new_symbol = extend ? run_symbol_ff : req_symbol;
   assign new_count  = extend ? run_count_ff + 16'd1 : 16'd1;

   always_comb begin
      run_symbol_in  = run_symbol_ff;
      run_count_in   = run_count_ff;
      run_open_in    = run_open_ff;
      pend_in        = pend_ff;
      pend_symbol_in = pend_symbol_ff;
      push_valid     = 1'b0;
      push_entry     = '{symbol: run_symbol_ff, count: run_count_ff, final_token: 1'b0};
      if (pend_ff) begin
         push_entry = '{symbol: pend_symbol_ff, count: 16'd1, final_token: 1'b1};
         if (!fifo_status.full) begin
            push_valid = 1'b1;
            pend_in    = 1'b0;
         end
      end else if (accept) begin
         run_symbol_in = new_symbol;
         run_count_in  = new_count;
         run_open_in   = 1'b1;
         if (!extend && run_open_ff) begin
            push_valid = 1'b1;
            if (req_last) begin
               pend_in        = 1'b1;
               pend_symbol_in = req_symbol;
            end
         end else if (req_last) begin
            push_valid = 1'b1;
            push_entry = '{symbol: new_symbol, count: new_count, final_token: 1'b1};
         end
         if (req_last) begin
            run_symbol_in = '0;
            run_count_in  = '0;
            run_open_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_symbol_ff <= '0;
         run_count_ff  <= '0;
         run_open_ff   <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         run_symbol_ff <= run_symbol_in;
         run_count_ff  <= run_count_in;
         run_open_ff   <= run_open_in;
         pend_ff       <= pend_in;
      end
      pend_symbol_ff <= pend_symbol_in;
   end

   // A pending final token is always followed by its push before a new word is taken.
   a_pend_blocks_input: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_tready)
      else $error("front accepted a word while a final token was pending");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !fifo_status.full)
      else $error("front pushed into a full queue");

   a_closed_run_is_clear: assert property (@(posedge clock) disable iff (reset)
      !run_open_ff |-> run_count_ff == '0)
      else $error("closed run still holds a count");

endmodule

`default_nettype wire

>>> sv/rlte_fifo.sv
// Short register queue of token requests between the front and back ends.
// Depends on rlte_pkg for the entry and status types.
`default_nettype none

module rlte_fifo #(
   parameter int DEPTH = rlte_pkg::FIFO_DEPTH
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             push,
   input  wire  rlte_pkg::entry_type       push_entry,
   input  wire                             pop,
   output rlte_pkg::entry_type             head,
   output rlte_pkg::fifo_status_type       status
);
   import rlte_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          storage_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) return '0;
      return p + PTR_W'(1);
   endfunction

   assign head         = storage_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (!push && pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) storage_ff[wr_ptr_ff] <= push_entry;
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count failed to grow on a push");

endmodule

`default_nettype wire

>>> sv/rlte_back.sv
// Back end of the run-length token encoder: packs queued run requests into tokens
// and holds them in the output register. Depends on rlte_pkg.
`default_nettype none

module rlte_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  rlte_pkg::cfg_type          cfg,
   input  wire  rlte_pkg::entry_type        head,
   input  wire  rlte_pkg::fifo_status_type  fifo_status,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [rlte_pkg::VALUE_W-1:0]     rsp_value,
   output logic [rlte_pkg::LENGTH_W-1:0]    rsp_length,
   output logic                             rsp_final
);
   import rlte_pkg::*;

   logic                  valid_ff, valid_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;
   logic                  final_ff, final_in;

   logic [SYM_BITS_W-1:0] sb;
   logic [CNT_BITS_W-1:0] cb;
   logic [SYMBOL_W-1:0]   code_mask;
   logic [SYMBOL_W-1:0]   code;
   logic [COUNT_W-1:0]    mc;
   logic [COUNT_W-1:0]    cnt;
   logic [SYMBOL_W:0]     mask_wide;

   assign pop = !fifo_status.empty && (!valid_ff || rsp_tready);

   always_comb begin
      sb        = eff_sym_bits(cfg.symbol_bits);
      cb        = eff_cnt_bits(cfg.count_bits);
      mc        = max_count(cfg.count_bits);
      mask_wide = (9'd1 << sb) - 9'd1;
      code_mask = mask_wide[SYMBOL_W-1:0];
      code      = (head.symbol - cfg.symbol_offset) & code_mask;
      cnt       = (head.count > mc) ? mc : head.count;
      if (cnt <= 16'd1) begin
         value_in  = {17'd0, code} << 1;
         length_in = {1'b0, sb} + 5'd1;
      end else begin
         value_in  = ({17'd0, code} << (cb + 5'd1)) | (25'd1 << cb) | {9'd0, cnt};
         length_in = {1'b0, sb} + 5'd1 + cb;
      end
      final_in = head.final_token;
      valid_in = valid_ff;
      if (pop) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         value_ff  <= value_in;
         length_ff <= length_in;
         final_ff  <= final_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_length = length_ff;
   assign rsp_final  = final_ff;

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped token did not reach the output register");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (length_ff >= 5'd2 && length_ff <= 5'd25))
      else $error("token length out of range");

   a_pop_only_with_room: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !pop)
      else $error("token popped over a stalled output word");

endmodule

`default_nettype wire

>>> sv/run_length_token_encoder_top.sv
// Top level of the run-length token encoder: configuration registers and the
// front end, token queue and back end. Depends on rlte_pkg, rlte_front, rlte_fifo, rlte_back.
`default_nettype none

// The encoder takes one character word per clock cycle and emits one token word per clock
// cycle unless stalled. The front end keeps the open run and, when a run closes, puts a
// request into a queue of FIFO_DEPTH entries; the back end packs it and registers the token,
// so a token passes through the queue and the output register. A character that both
// closes a run and ends the text yields two tokens and holds the input until the second
// request is pushed, since the queue takes one request a cycle. Configuration writes are
// always taken in the cycle they are offered and must be made while the block is idle.
module run_length_token_encoder_top #(
   parameter int FIFO_DEPTH = rlte_pkg::FIFO_DEPTH
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [rlte_pkg::REQ_DATA_W-1:0]      req_tdata,  // [7:0] symbol
   input  wire                                  req_tlast,  // end_of_text
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [rlte_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [24:0] token_value, [29:25] token_length
   output logic                                 rsp_tlast,  // final_token
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [rlte_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [rlte_pkg::CSR_DATA_W-1:0]      csr_data
);
   import rlte_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   fifo_status_type  fifo_status;
   entry_type        push_entry;
   entry_type        head;
   logic             push_valid;
   logic             pop;
   logic [VALUE_W-1:0]  rsp_value;
   logic [LENGTH_W-1:0] rsp_length;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYMBOL_OFFSET: cfg_in.symbol_offset = csr_data;
            CSR_SYMBOL_BITS:   cfg_in.symbol_bits   = csr_data[SYM_BITS_W-1:0];
            CSR_COUNT_BITS:    cfg_in.count_bits    = csr_data[CNT_BITS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{symbol_offset: RST_SYMBOL_OFFSET, symbol_bits: RST_SYMBOL_BITS,
                     count_bits: RST_COUNT_BITS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_symbol  (req_tdata[SYMBOL_W-1:0]),
      .req_last    (req_tlast),
      .fifo_status (fifo_status),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   rlte_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   rlte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_length  (rsp_length),
      .rsp_final   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_length, rsp_value};

endmodule

`default_nettype wire

>>> sim/run_length_token_encoder_top_test.sv
// Self-checking testbench for the run-length token encoder: drives character words, predicts
// the packed tokens and checks every token word field by field. Needs only rlte_pkg and the
// top level run_length_token_encoder_top.
`default_nettype none

module run_length_token_encoder_top_test;
   import rlte_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 55;
   localparam int PHASES       = 8;

   typedef struct {
      logic [SYMBOL_W-1:0] symbol;
      logic                end_of_text;
   } char_type;

   typedef struct {
      logic [VALUE_W-1:0]  value;
      logic [LENGTH_W-1:0] length;
      logic                is_last;
   } token_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0]  rsp_tdata;
   wire                    rsp_tlast;
   logic                   csr_valid  = 1'b0;
   wire                    csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Shadow copy of the registers and of the open run.
   logic [SYMBOL_W-1:0]   cfg_offset   = RST_SYMBOL_OFFSET;
   logic [SYM_BITS_W-1:0] cfg_sym_bits = RST_SYMBOL_BITS;
   logic [CNT_BITS_W-1:0] cfg_cnt_bits = RST_COUNT_BITS;
   logic [SYMBOL_W-1:0]   run_sym      = '0;
   logic [COUNT_W-1:0]    run_cnt      = '0;
   logic                  run_open     = 1'b0;

   char_type  pending_chars[$];
   token_type expected_tokens[$];
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;
   int        error_count    = 0;
   int        cycle_count    = 0;

   run_length_token_encoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned code_width();
      int unsigned b;
      b = {28'd0, cfg_sym_bits};
      if (b < 1) b = 1;
      if (b > 8) b = 8;
      return b;
   endfunction

   function automatic int unsigned count_width();
      int unsigned b;
      b = {27'd0, cfg_cnt_bits};
      if (b < 1) b = 1;
      if (b > 16) b = 16;
      return b;
   endfunction

   function automatic int unsigned longest_run();
      return (1 << count_width()) - 1;
   endfunction

   function automatic token_type pack_token(logic [SYMBOL_W-1:0] sym, int unsigned cnt,
                                            logic last);
      token_type         t;
      int unsigned       sb;
      int unsigned       cb;
      int unsigned       code;
      int unsigned       n;
      longint unsigned   v;
      sb   = code_width();
      cb   = count_width();
      n    = (cnt > longest_run()) ? longest_run() : cnt;
      code = (int'(sym) - int'(cfg_offset)) & ((1 << sb) - 1);
      if (n <= 1) begin
         v        = 64'(code) << 1;
         t.length = LENGTH_W'(sb + 1);
      end else begin
         v        = (64'(code) << (cb + 1)) | (64'd1 << cb) | 64'(n);
         t.length = LENGTH_W'(sb + 1 + cb);
      end
      t.value   = v[VALUE_W-1:0];
      t.is_last = last;
      return t;
   endfunction

   function automatic void encode_char(char_type c);
      if (run_open && c.symbol == run_sym && {16'd0, run_cnt} < longest_run()) begin
         run_cnt = run_cnt + COUNT_W'(1);
      end else begin
         if (run_open) expected_tokens.push_back(pack_token(run_sym, {16'd0, run_cnt}, 1'b0));
         run_sym  = c.symbol;
         run_cnt  = COUNT_W'(1);
         run_open = 1'b1;
      end
      if (c.end_of_text) begin
         expected_tokens.push_back(pack_token(run_sym, {16'd0, run_cnt}, 1'b1));
         run_open = 1'b0;
         run_cnt  = '0;
         run_sym  = '0;
      end
   endfunction

   always @(posedge clock) begin : drive_chars
      logic hold;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         hold = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            encode_char(pending_chars.pop_front());
         end
         if (!hold) begin
            if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_chars[0].symbol;
               req_tlast  <= pending_chars[0].end_of_text;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_tokens
      token_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected token word %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tdata[24:0] !== want.value) begin
                  $error("token_value: expected %h, got %h", want.value, rsp_tdata[24:0]);
                  error_count++;
               end
               if (rsp_tdata[29:25] !== want.length) begin
                  $error("token_length: expected %0d, got %0d", want.length, rsp_tdata[29:25]);
                  error_count++;
               end
               if (rsp_tlast !== want.is_last) begin
                  $error("final_token: expected %b, got %b", want.is_last, rsp_tlast);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SYMBOL_OFFSET: cfg_offset   = data;
         CSR_SYMBOL_BITS:   cfg_sym_bits = data[SYM_BITS_W-1:0];
         CSR_COUNT_BITS:    cfg_cnt_bits = data[CNT_BITS_W-1:0];
         default: ;
      endcase
   endtask

   // Upper data bits lie outside the register fields and are filled with noise.
   task automatic set_config(logic [7:0] offset, logic [3:0] sym_bits, logic [4:0] cnt_bits);
      write_csr(CSR_SYMBOL_OFFSET, offset);
      write_csr(CSR_SYMBOL_BITS, {4'($urandom_range(15)), sym_bits});
      write_csr(CSR_COUNT_BITS, {3'($urandom_range(7)), cnt_bits});
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (pending_chars.size() != 0 || expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_char(logic [7:0] sym, logic eot);
      char_type c;
      c.symbol      = sym;
      c.end_of_text = eot;
      pending_chars.push_back(c);
   endtask

   task automatic queue_run(logic [7:0] sym, int n);
      repeat (n) queue_char(sym, 1'b0);
   endtask

   // Mostly whole texts built from runs of a few symbols, with some stray characters.
   task automatic queue_texts(int target);
      int          n;
      int          runs;
      int          len;
      int unsigned cap;
      logic [7:0]  base;
      logic [7:0]  sym;
      n   = 0;
      cap = (longest_run() + 2 > 40) ? 40 : longest_run() + 2;
      while (n < target) begin
         if ($urandom_range(9) == 0) begin
            queue_char(8'($urandom_range(255)), $urandom_range(7) == 0);
            n++;
         end else begin
            base = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                            : cfg_offset + 8'($urandom_range(4));
            runs = $urandom_range(1, 6);
            for (int r = 0; r < runs; r++) begin
               sym = base + 8'($urandom_range(3));
               len = ($urandom_range(3) == 0) ? $urandom_range(1, cap) : $urandom_range(1, 4);
               queue_run(sym, len - 1);
               queue_char(sym, r == runs - 1);
               n += len;
            end
         end
      end
   endtask

   initial begin : run_test
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_char("A", 1'b0);
      queue_run("B", 5);
      queue_char(8'h00, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char("C", 1'b0);
      queue_char("D", 1'b1);
      settle();
      set_config(8'd64, 4'd3, 5'd2);
      queue_run("E", 4);
      queue_char("E", 1'b1);
      queue_char("F", 1'b1);
      settle();
      set_config(8'd64, 4'd3, 5'd4);
      queue_run("G", 6);
      settle();
      set_config(8'd64, 4'd3, 5'd2);
      write_csr(CSR_UNUSED, 8'hA5);
      csr_valid <= 1'b0;
      queue_char("G", 1'b0);
      queue_char("H", 1'b1);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       set_config(8'd0, 4'd8, 5'd16);
            1:       set_config(8'd255, 4'd1, 5'd1);
            2:       set_config(8'($urandom_range(255)), 4'd0, 5'd0);
            3:       set_config(8'($urandom_range(255)), 4'd15, 5'd31);
            default: set_config(8'($urandom_range(255)), 4'($urandom_range(15)),
                                5'($urandom_range(31)));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         queue_texts(PHASE_ITEMS);
         settle();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
